@@ design/stc_pkg.sv @@
// Package: types, constants and template ROM for the spectral template classifier.
package stc_pkg;

	localparam int NUM_BANDS = 4;
	localparam int NUM_CLASSES = 5;
	localparam int FRACTION_BITS = 16;
	localparam int ERR_OUT_FRAC = 30;
	localparam int BAND_W = 32;
	localparam int CLASS_W = 3;
	localparam int NORM_W = FRACTION_BITS + 1;
	localparam int SQ_W = 2 * NORM_W;
	localparam int ERR_W = SQ_W + $clog2(NUM_BANDS) + 1;
	localparam int BAND_IDX_W = $clog2(NUM_BANDS);
	localparam int DIV_STEPS = FRACTION_BITS;
	localparam int DIVS_PER_STAGE = 2;
	localparam int DIV_STAGES = (DIV_STEPS + DIVS_PER_STAGE - 1) / DIVS_PER_STAGE;
	localparam int QUO_W = DIVS_PER_STAGE * DIV_STAGES + 1;
	localparam int SHIFT_W = $clog2(BAND_W + 1);

	typedef struct packed {
		logic [BAND_W-1:0] band3_strength;
		logic [BAND_W-1:0] band2_strength;
		logic [BAND_W-1:0] band1_strength;
		logic [BAND_W-1:0] band0_strength;
	} in_item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] best_class;
		logic undetermined;
		logic [31:0] least_error;
	} out_item_t;

	typedef logic [NORM_W-1:0] norm_vec_t [NUM_BANDS];

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// templates pre-normalized: floor(entry * 2^16 / row max)
	//   warship   200 150 60 20
	//   escort    100 120 80 60
	//   merchant  120 100 80 40
	//   submarine  50  50 40 30
	//   torpedo    10  40 80 70
	localparam logic [NORM_W-1:0] TMPL_ROM [NUM_CLASSES][NUM_BANDS] = '{
		'{17'd65536, 17'd49152, 17'd19660, 17'd6553},
		'{17'd54613, 17'd65536, 17'd43690, 17'd32768},
		'{17'd65536, 17'd54613, 17'd43690, 17'd21845},
		'{17'd65536, 17'd65536, 17'd52428, 17'd39321},
		'{17'd8192, 17'd32768, 17'd65536, 17'd57344}
	};

	function automatic logic [NORM_W-1:0] tmpl(input int k, input int i);
		if (k < 0 || k >= NUM_CLASSES || i < 0 || i >= NUM_BANDS)
			return '0;
		return TMPL_ROM[k][i];
	endfunction

endpackage

@@ design/stc_div_cell.sv @@
// Divider cell: DIVS_PER_STAGE (two) restoring quotient steps for every band, then a register.
module stc_div_cell (
	input  logic clk,
	input  logic [stc_pkg::BAND_W-1:0] den_in,
	input  logic [stc_pkg::BAND_W:0] rem_in [stc_pkg::NUM_BANDS],
	input  logic [stc_pkg::QUO_W-1:0] quo_in [stc_pkg::NUM_BANDS],
	input  stc_pkg::ctl_t ctl_in,
	input  logic arst_n,
	output logic [stc_pkg::BAND_W-1:0] den_out,
	output logic [stc_pkg::BAND_W:0] rem_out [stc_pkg::NUM_BANDS],
	output logic [stc_pkg::QUO_W-1:0] quo_out [stc_pkg::NUM_BANDS],
	output stc_pkg::ctl_t ctl_out
);
	logic [stc_pkg::BAND_W:0] rem_d [stc_pkg::NUM_BANDS];
	logic [stc_pkg::QUO_W-1:0] quo_d [stc_pkg::NUM_BANDS];

	always_comb begin
		logic [stc_pkg::BAND_W+1:0] t;
		t = '0;
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++) begin
			rem_d[b] = rem_in[b];
			quo_d[b] = quo_in[b];
			for (int s = 0; s < stc_pkg::DIVS_PER_STAGE; s++) begin
				t = {rem_d[b], 1'b0};
				quo_d[b] = {quo_d[b][stc_pkg::QUO_W-2:0], 1'b0};
				if (t >= {2'b00, den_in}) begin
					t = t - {2'b00, den_in};
					quo_d[b][0] = 1'b1;
				end
				rem_d[b] = t[stc_pkg::BAND_W:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		den_out <= den_in;
		rem_out <= rem_d;
		quo_out <= quo_d;
	end
endmodule

@@ design/stc_class_cell.sv @@
// Class cell: squared error against one template, running minimum handed on.
module stc_class_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [3:0] class_idx,
	input  stc_pkg::norm_vec_t norm_in,
	input  stc_pkg::ctl_t ctl_in,
	input  logic [stc_pkg::ERR_W-1:0] best_err_in,
	input  logic [stc_pkg::CLASS_W-1:0] best_in,
	output stc_pkg::norm_vec_t norm_out,
	output stc_pkg::ctl_t ctl_out,
	output logic [stc_pkg::ERR_W-1:0] best_err_out,
	output logic [stc_pkg::CLASS_W-1:0] best_out
);
	logic [stc_pkg::SQ_W-1:0] sq_s1 [stc_pkg::NUM_BANDS];
	stc_pkg::norm_vec_t norm_s1;
	stc_pkg::ctl_t ctl_s1;
	logic [stc_pkg::ERR_W-1:0] best_err_s1;
	logic [stc_pkg::CLASS_W-1:0] best_s1;
	logic [stc_pkg::ERR_W-1:0] err;

	always_comb begin
		err = '0;
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++)
			err = err + stc_pkg::ERR_W'(sq_s1[b]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_out <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_out <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++) begin
			logic [stc_pkg::NORM_W-1:0] t, d;
			t = stc_pkg::tmpl(int'(class_idx), b);
			d = (norm_in[b] >= t) ? norm_in[b] - t : t - norm_in[b];
			sq_s1[b] <= d * d;
		end
		norm_s1 <= norm_in;
		best_err_s1 <= best_err_in;
		best_s1 <= best_in;
		norm_out <= norm_s1;
		if (class_idx == 4'd0 || err < best_err_s1) begin
			best_err_out <= err;
			best_out <= stc_pkg::CLASS_W'(class_idx);
		end else begin
			best_err_out <= best_err_s1;
			best_out <= best_s1;
		end
	end
endmodule

@@ design/spectral_template_classifier.sv @@
// Top level: spectral template classifier, peak search, divider chain, class chain.
// channel | signals                 | transfer
// input   | start, busy, in_item    | start && !busy
// result  | done, out_item          | done (one cycle, no stall)
// One item per cycle; done rises after the input register, the DIV_STAGES divider
// cells (two quotient bits each), two stages per class cell and the output register.
// busy is always low. Reset clears all valid flags; payload is not reset.
module spectral_template_classifier (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  stc_pkg::in_item_t in_item,
	output logic busy,
	output logic done,
	output stc_pkg::out_item_t out_item
);
	localparam int DS = stc_pkg::DIV_STAGES;
	localparam int NC = stc_pkg::NUM_CLASSES;

	logic [stc_pkg::BAND_W-1:0] band_s1 [stc_pkg::NUM_BANDS];
	logic [stc_pkg::BAND_W-1:0] peak_s1;
	stc_pkg::ctl_t ctl_s1;

	logic [stc_pkg::BAND_W-1:0] den_c [DS+1];
	logic [stc_pkg::BAND_W:0] rem_c [DS+1][stc_pkg::NUM_BANDS];
	logic [stc_pkg::QUO_W-1:0] quo_c [DS+1][stc_pkg::NUM_BANDS];
	stc_pkg::ctl_t dctl_c [DS+1];

	stc_pkg::norm_vec_t norm_c [NC+1];
	stc_pkg::ctl_t cctl_c [NC+1];
	logic [stc_pkg::ERR_W-1:0] berr_c [NC+1];
	logic [stc_pkg::CLASS_W-1:0] best_c [NC+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start;
			ctl_s1.zero <= (in_item == '0);
		end
	end

	always_ff @(posedge clk) begin
		logic [stc_pkg::BAND_W-1:0] pk;
		pk = '0;
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++) begin
			band_s1[b] <= in_item[b*stc_pkg::BAND_W +: stc_pkg::BAND_W];
			if (in_item[b*stc_pkg::BAND_W +: stc_pkg::BAND_W] > pk)
				pk = in_item[b*stc_pkg::BAND_W +: stc_pkg::BAND_W];
		end
		peak_s1 <= pk;
	end

	// integer quotient bit (x >= peak) here, fraction bits in the cells
	always_comb begin
		den_c[0] = peak_s1;
		dctl_c[0] = ctl_s1;
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++) begin
			quo_c[0][b] = '0;
			if (band_s1[b] >= peak_s1) begin
				rem_c[0][b] = {1'b0, band_s1[b] - peak_s1};
				quo_c[0][b][0] = 1'b1;
			end else begin
				rem_c[0][b] = {1'b0, band_s1[b]};
			end
		end
	end

	for (genvar g = 0; g < DS; g++) begin : g_div
		stc_div_cell u_div (
			.clk(clk), .arst_n(arst_n),
			.den_in(den_c[g]), .rem_in(rem_c[g]), .quo_in(quo_c[g]), .ctl_in(dctl_c[g]),
			.den_out(den_c[g+1]), .rem_out(rem_c[g+1]), .quo_out(quo_c[g+1]),
			.ctl_out(dctl_c[g+1])
		);
	end

	// drop the spare quotient bit when the cells step past FRACTION_BITS
	always_comb begin
		for (int b = 0; b < stc_pkg::NUM_BANDS; b++)
			norm_c[0][b] = stc_pkg::NORM_W'(quo_c[DS][b] >>
				(stc_pkg::QUO_W - 1 - stc_pkg::FRACTION_BITS));
		cctl_c[0] = dctl_c[DS];
		berr_c[0] = '0;
		best_c[0] = '0;
	end

	for (genvar k = 0; k < NC; k++) begin : g_cls
		stc_class_cell u_cls (
			.clk(clk), .arst_n(arst_n), .class_idx(4'(k)),
			.norm_in(norm_c[k]), .ctl_in(cctl_c[k]),
			.best_err_in(berr_c[k]), .best_in(best_c[k]),
			.norm_out(norm_c[k+1]), .ctl_out(cctl_c[k+1]),
			.best_err_out(berr_c[k+1]), .best_out(best_c[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cctl_c[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [stc_pkg::ERR_W+31:0] r;
		if (2*stc_pkg::FRACTION_BITS >= stc_pkg::ERR_OUT_FRAC)
			r = (stc_pkg::ERR_W+32)'(berr_c[NC]) >>
				(2*stc_pkg::FRACTION_BITS - stc_pkg::ERR_OUT_FRAC);
		else
			r = (stc_pkg::ERR_W+32)'(berr_c[NC]) <<
				(stc_pkg::ERR_OUT_FRAC - 2*stc_pkg::FRACTION_BITS);
		if (cctl_c[NC].zero) begin
			out_item.best_class <= '0;
			out_item.undetermined <= 1'b1;
			out_item.least_error <= '0;
		end else begin
			out_item.best_class <= best_c[NC];
			out_item.undetermined <= 1'b0;
			out_item.least_error <= (r > (stc_pkg::ERR_W+32)'(32'hFFFFFFFF)) ?
				32'hFFFFFFFF : r[31:0];
		end
	end

	property p_done_follows;
		@(posedge clk) disable iff (!arst_n) cctl_c[NC].valid |=> done;
	endproperty
	a_done_follows: assert property (p_done_follows) else $error("result strobe lost");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_item.best_class < 3'(NC)) else $error("class out of range");
endmodule
